[src/psw_pkg.sv]
// Shared constants, types and helpers for the setpoint-weighted PID block.
// Used by psw_mul and pid_setpoint_weighted_antiwindup; no dependencies.
`default_nettype none

package psw_pkg;

  localparam int unsigned TEMP_W    = 10;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned DRIVE_W   = 8;
  localparam int unsigned LIM_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned FRAC_W    = 12;

  localparam int unsigned ACC_W  = 40;                 // integral and back-calc state
  localparam int unsigned SUM_W  = 44;                 // working sums, Q.12
  localparam int unsigned MA_W   = 44;                 // multiplicand
  localparam int unsigned PROD_W = MA_W + GAIN_W;      // full product
  localparam int unsigned SH_W   = PROD_W - FRAC_W;    // product after >> 12
  localparam int unsigned WACC_W = TEMP_W + WGT_W;     // target times weight
  localparam int unsigned ERR_W  = 26;                 // weighted errors, Q.12

  localparam int unsigned OUTPUT_MAX = 255;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(OUTPUT_MAX);
  localparam logic [SUM_W-1:0]   LIM_HI_Q  = SUM_W'(OUTPUT_MAX) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KB       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 3'd7;

  localparam logic [LIM_W-1:0] LIM_IN_RANGE = 2'd0;
  localparam logic [LIM_W-1:0] LIM_HIGH     = 2'd1;
  localparam logic [LIM_W-1:0] LIM_LOW      = 2'd2;
  localparam logic [LIM_W-1:0] LIM_OFF      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_LIMIT,
    ST_MUL_B,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic              start;
    logic [MA_W-1:0]   a;
    logic [GAIN_W-1:0] k;
  } mul_req_t;

  // saturate a signed value to 40 bits
  function automatic logic [ACC_W-1:0] sat40(input logic [SH_W-1:0] v);
    logic [SH_W-ACC_W:0] hi;
    hi = v[SH_W-1:ACC_W-1];
    if ((&hi) || !(|hi)) begin
      return v[ACC_W-1:0];
    end else if (v[SH_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

[src/psw_mul.sv]
// Bit-serial signed-by-unsigned multiplier, one gain bit per cycle, LSB first.
// Stops early once the remaining gain bits are zero. Depends on psw_pkg.
`default_nettype none

module psw_mul import psw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mul_req_t          req_i,
  output logic                   busy_o,
  output logic [PROD_W-1:0]      prod_o
);

  logic              busy_q;
  logic [PROD_W-1:0] a_q;
  logic [PROD_W-1:0] acc_q;
  logic [GAIN_W-1:0] k_q;
  logic              k_zero;

  assign k_zero = (k_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && k_zero) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= {{(PROD_W-MA_W){req_i.a[MA_W-1]}}, req_i.a};
      k_q   <= req_i.k;
      acc_q <= '0;
    end else if (busy_q && !k_zero) begin
      if (k_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[PROD_W-2:0], 1'b0};
      k_q <= {1'b0, k_q[GAIN_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

[src/pid_setpoint_weighted_antiwindup.sv]
// When the heater is off an item skips the multiplies; otherwise its products go through
// one bit-serial multiplier, shared by four products with ki, kp, kd and kb.
// One item at a time: the next is taken the cycle after its result is loaded.
// Reset (async, active low) clears integral, back-calc and derivative state and
// loads the register defaults. Depends on psw_pkg and psw_mul.
`default_nettype none

module pid_setpoint_weighted_antiwindup import psw_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TEMP_W-1:0]    measured_temp_i,
  input  wire logic [TEMP_W-1:0]    target_temp_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [DRIVE_W-1:0]        drive_o,
  output logic [LIM_W-1:0]          limited_o
);

  // configuration
  logic [GAIN_W-1:0] kp_q, ki_q, kd_q, kb_q;
  logic [WGT_W-1:0]  b_weight_q, c_weight_q;
  logic [TEMP_W-1:0] max_temp_q, min_temp_q;

  // loop state
  logic [ACC_W-1:0]  integral_q, bc_q;
  logic [ERR_W-1:0]  last_q;

  st_e state_q, state_d;
  logic out_valid_q;

  // item working registers
  logic [TEMP_W-1:0] m_q, c_q, cs_q;
  logic [WACC_W-1:0] bws_q, cws_q, wb_q, wc_q;
  logic [SUM_W-1:0]  tot_q;
  logic [DRIVE_W-1:0] res_drive_q, drive_q;
  logic [LIM_W-1:0]   res_lim_q, lim_q;

  logic [TEMP_W-1:0] tgt_clamp;
  logic              heater_off, ws_done;
  logic              mul_busy;
  logic [PROD_W-1:0] mul_prod;
  mul_req_t          mul_req;
  logic              accept, load_out;

  logic [TEMP_W:0]   diff_cm;
  logic [ERR_W-1:0]  m_scaled, err_p, err_d;
  logic [ERR_W:0]    err_dd;
  logic [SUM_W-1:0]  integ_ext, bc_ext, i_sum, prod_q12, tot_p, tot_pd;
  logic [SUM_W-1:0]  clamped, bc_arg;
  logic              at_hi, at_lo;
  logic [ACC_W-1:0]  i_new, bc_new;

  assign tgt_clamp  = (target_temp_i > max_temp_q) ? max_temp_q : target_temp_i;
  assign heater_off = (c_q <= min_temp_q);
  assign ws_done    = (cs_q == '0);

  assign diff_cm  = {1'b0, c_q} - {1'b0, m_q};
  assign m_scaled = {4'b0, m_q, {FRAC_W{1'b0}}};
  assign err_p    = {2'b0, wb_q[WACC_W-1:2]} - m_scaled;
  assign err_d    = {2'b0, wc_q[WACC_W-1:2]} - m_scaled;
  assign err_dd   = {err_d[ERR_W-1], err_d} - {last_q[ERR_W-1], last_q};

  assign integ_ext = {{(SUM_W-ACC_W){integral_q[ACC_W-1]}}, integral_q};
  assign bc_ext    = {{(SUM_W-ACC_W){bc_q[ACC_W-1]}}, bc_q};
  assign i_sum     = integ_ext + mul_prod[SUM_W-1:0] + bc_ext;
  assign i_new     = sat40({{(SH_W-SUM_W){i_sum[SUM_W-1]}}, i_sum});
  assign prod_q12  = mul_prod[FRAC_W+SUM_W-1:FRAC_W];
  assign tot_p     = integ_ext + prod_q12;
  assign tot_pd    = tot_q + prod_q12;

  assign at_hi   = ($signed(tot_q) >= $signed(LIM_HI_Q));
  assign at_lo   = tot_q[SUM_W-1] || (tot_q == '0);
  assign clamped = at_hi ? LIM_HI_Q : (at_lo ? '0 : tot_q);
  assign bc_arg  = clamped - tot_q;
  assign bc_new  = sat40(mul_prod[PROD_W-1:FRAC_W]);

  psw_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .prod_o (mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = heater_off ? ST_DONE : ST_MUL_I;
      ST_MUL_I: if (!mul_busy && ws_done) state_d = ST_MUL_P;
      ST_MUL_P: if (!mul_busy) state_d = ST_MUL_D;
      ST_MUL_D: if (!mul_busy) state_d = ST_LIMIT;
      ST_LIMIT: state_d = ST_MUL_B;
      ST_MUL_B: if (!mul_busy) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o    = 1'b0;
    load_out      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.k     = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_CHECK: begin
        mul_req.start = !heater_off;
        mul_req.a     = {{(MA_W-TEMP_W-1){diff_cm[TEMP_W]}}, diff_cm};
        mul_req.k     = ki_q;
      end
      ST_MUL_I: begin
        mul_req.start = !mul_busy && ws_done;
        mul_req.a     = {{(MA_W-ERR_W){err_p[ERR_W-1]}}, err_p};
        mul_req.k     = kp_q;
      end
      ST_MUL_P: begin
        mul_req.start = !mul_busy;
        mul_req.a     = {{(MA_W-ERR_W-1){err_dd[ERR_W]}}, err_dd};
        mul_req.k     = kd_q;
      end
      ST_LIMIT: begin
        mul_req.start = 1'b1;
        mul_req.a     = bc_arg;
        mul_req.k     = kb_q;
      end
      ST_DONE: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      kb_q       <= '0;
      b_weight_q <= 16'd16384;
      c_weight_q <= 16'd16384;
      max_temp_q <= 10'd275;
      min_temp_q <= 10'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:       kp_q       <= cfg_wdata_i;
        REG_KI:       ki_q       <= cfg_wdata_i;
        REG_KD:       kd_q       <= cfg_wdata_i;
        REG_KB:       kb_q       <= cfg_wdata_i;
        REG_B_WEIGHT: b_weight_q <= cfg_wdata_i[WGT_W-1:0];
        REG_C_WEIGHT: c_weight_q <= cfg_wdata_i[WGT_W-1:0];
        REG_MAX_TEMP: max_temp_q <= cfg_wdata_i[TEMP_W-1:0];
        REG_MIN_TEMP: min_temp_q <= cfg_wdata_i[TEMP_W-1:0];
        default:      kp_q       <= kp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      bc_q       <= '0;
      last_q     <= '0;
      cs_q       <= '0;
    end else begin
      case (state_q)
        ST_CHECK: begin
          if (heater_off) begin
            integral_q <= '0;
            last_q     <= '0;
          end else begin
            cs_q <= c_q;
          end
        end
        ST_MUL_I: begin
          if (!mul_busy && ws_done) integral_q <= i_new;
        end
        ST_LIMIT: begin
          last_q <= err_d;
        end
        ST_MUL_B: begin
          if (!mul_busy) bc_q <= bc_new;
        end
        default: begin
          last_q <= last_q;
        end
      endcase
      if (state_q != ST_CHECK && !ws_done) begin
        cs_q <= {1'b0, cs_q[TEMP_W-1:1]};
      end
    end
  end

  // target-times-weight products, one target bit per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      bws_q <= {{TEMP_W{1'b0}}, b_weight_q};
      cws_q <= {{TEMP_W{1'b0}}, c_weight_q};
      wb_q  <= '0;
      wc_q  <= '0;
    end else if (!ws_done) begin
      if (cs_q[0]) begin
        wb_q <= wb_q + bws_q;
        wc_q <= wc_q + cws_q;
      end
      bws_q <= {bws_q[WACC_W-2:0], 1'b0};
      cws_q <= {cws_q[WACC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q <= measured_temp_i;
      c_q <= tgt_clamp;
    end
    if (state_q == ST_MUL_P && !mul_busy) tot_q <= tot_p;
    if (state_q == ST_MUL_D && !mul_busy) tot_q <= tot_pd;
    if (state_q == ST_CHECK) begin
      res_drive_q <= '0;
      res_lim_q   <= LIM_OFF;
    end
    if (state_q == ST_LIMIT) begin
      if (at_hi) begin
        res_drive_q <= DRIVE_MAX;
        res_lim_q   <= LIM_HIGH;
      end else if (at_lo) begin
        res_drive_q <= '0;
        res_lim_q   <= LIM_LOW;
      end else begin
        res_drive_q <= tot_q[FRAC_W+DRIVE_W-1:FRAC_W];
        res_lim_q   <= LIM_IN_RANGE;
      end
    end
    if (load_out) begin
      drive_q <= res_drive_q;
      lim_q   <= res_lim_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign limited_o   = lim_q;

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && heater_off) |=>
      (integral_q == '0 && last_q == '0 && state_q == ST_DONE))
    else $error("heater off did not clear loop state");

  a_hi_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && limited_o == LIM_HIGH) |-> (drive_o == DRIVE_MAX))
    else $error("clamped high item without full drive");

  a_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (limited_o == LIM_LOW || limited_o == LIM_OFF)) |-> (drive_o == '0))
    else $error("clamped low or off item with nonzero drive");

  a_weights_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_P) |-> ws_done)
    else $error("weighted errors used before target products finished");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_busy)
    else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

[tb/sv/pid_duty_monitor.sv]
// Monitor for pid_setpoint_weighted_antiwindup: tracks register writes, predicts each duty
// result and compares it with what leaves the output channel. Depends on psw_pkg.
`timescale 1ns / 100ps

module pid_duty_monitor import psw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TEMP_W-1:0]    measured_temp_i,
  input  logic [TEMP_W-1:0]    target_temp_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DRIVE_W-1:0]   drive_i,
  input  logic [LIM_W-1:0]     limited_i,
  output int                   awaiting_o,
  output int                   mismatches_o
);

  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [LIM_W-1:0]   limited;
  } duty_t;

  logic [GAIN_W-1:0] kp_r, ki_r, kd_r, kb_r;
  logic [WGT_W-1:0]  bw_r, cw_r;
  logic [TEMP_W-1:0] tmax_r, tmin_r;

  longint integ_acc, backcalc_acc, last_derr;
  duty_t  duty_due_q [$];
  int     result_no;
  int     mismatch_cnt;

  function automatic longint clamp40(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // floor(k * a / 4096), saturated to 40 bits
  function automatic longint gain_mul(input logic [GAIN_W-1:0] k, input longint a);
    logic        neg;
    logic [63:0] mag;
    logic [87:0] prod;
    logic [75:0] q;
    neg  = a < 0;
    mag  = neg ? 64'(-a) : 64'(a);
    prod = {24'd0, mag} * {64'd0, k};
    q    = prod[87:12];
    if (neg && prod[11:0] != 12'd0) q = q + 76'd1;
    if (neg) begin
      if (q >= 76'd549755813888) return ACC_LO;
      return -longint'(q[39:0]);
    end
    if (q > 76'd549755813887) return ACC_HI;
    return longint'(q[39:0]);
  endfunction

  task automatic pid_step(input logic [TEMP_W-1:0] meas, input logic [TEMP_W-1:0] tgt,
                          output duty_t res);
    longint c, m, err_p, err_d, err_i, total, clamped, lim_hi;
    c      = longint'(tgt);
    m      = longint'(meas);
    lim_hi = longint'(OUTPUT_MAX) <<< FRAC_W;
    if (c > longint'(tmax_r)) c = longint'(tmax_r);
    if (c <= longint'(tmin_r)) begin
      integ_acc   = 0;
      last_derr   = 0;
      res.drive   = '0;
      res.limited = LIM_OFF;
    end else begin
      err_p     = ((c * longint'(bw_r)) >>> 2) - (m <<< FRAC_W);
      err_d     = ((c * longint'(cw_r)) >>> 2) - (m <<< FRAC_W);
      err_i     = (c - m) * longint'(ki_r);
      integ_acc = clamp40(integ_acc + err_i + backcalc_acc);
      total     = gain_mul(kp_r, err_p) + integ_acc + gain_mul(kd_r, err_d - last_derr);
      if (total >= lim_hi) begin
        clamped     = lim_hi;
        res.drive   = DRIVE_MAX;
        res.limited = LIM_HIGH;
      end else if (total <= 0) begin
        clamped     = 0;
        res.drive   = '0;
        res.limited = LIM_LOW;
      end else begin
        clamped     = total;
        res.drive   = DRIVE_W'(total >>> FRAC_W);
        res.limited = LIM_IN_RANGE;
      end
      backcalc_acc = gain_mul(kb_r, clamped - total);
      last_derr    = err_d;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: result %0d: %s", $time, result_no, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_t want, got;
    if (!rst_ni) begin
      kp_r         = '0;
      ki_r         = '0;
      kd_r         = '0;
      kb_r         = '0;
      bw_r         = WGT_W'(16384);
      cw_r         = WGT_W'(16384);
      tmax_r       = TEMP_W'(275);
      tmin_r       = TEMP_W'(5);
      integ_acc    = 0;
      backcalc_acc = 0;
      last_derr    = 0;
      result_no    = 0;
      mismatch_cnt = 0;
      duty_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP:       kp_r   = cfg_wdata_i[GAIN_W-1:0];
          REG_KI:       ki_r   = cfg_wdata_i[GAIN_W-1:0];
          REG_KD:       kd_r   = cfg_wdata_i[GAIN_W-1:0];
          REG_KB:       kb_r   = cfg_wdata_i[GAIN_W-1:0];
          REG_B_WEIGHT: bw_r   = cfg_wdata_i[WGT_W-1:0];
          REG_C_WEIGHT: cw_r   = cfg_wdata_i[WGT_W-1:0];
          REG_MAX_TEMP: tmax_r = cfg_wdata_i[TEMP_W-1:0];
          REG_MIN_TEMP: tmin_r = cfg_wdata_i[TEMP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.drive   = drive_i;
        got.limited = limited_i;
        if (duty_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item, drive %0d limited %0d",
                                    got.drive, got.limited));
        end else begin
          want = duty_due_q.pop_front();
          if (got.drive !== want.drive)
            report_mismatch($sformatf("drive expected %0d, got %0d", want.drive, got.drive));
          if (got.limited !== want.limited)
            report_mismatch($sformatf("limited expected %0d, got %0d",
                                      want.limited, got.limited));
        end
        result_no++;
      end
      if (in_valid_i && in_ready_i) begin
        pid_step(measured_temp_i, target_temp_i, want);
        duty_due_q.push_back(want);
      end
    end
    awaiting_o   = duty_due_q.size();
    mismatches_o = mismatch_cnt;
  end

endmodule

[tb/sv/tb_pid_setpoint_weighted_antiwindup.sv]
// Top of the pid_setpoint_weighted_antiwindup testbench: clock, reset, register phases,
// temperature items and output back-pressure. Checking sits in pid_duty_monitor; needs psw_pkg.
`timescale 1ns / 100ps

module tb_pid_setpoint_weighted_antiwindup import psw_pkg::*;;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [TEMP_W-1:0]    meas_temp;
  logic [TEMP_W-1:0]    targ_temp;
  logic                 out_valid;
  logic                 out_ready;
  logic [DRIVE_W-1:0]   drive;
  logic [LIM_W-1:0]     limited;

  int                   awaiting;
  int                   mismatches;
  logic [CFG_DAT_W-1:0] plan [8];
  logic                 no_gaps;

  pid_setpoint_weighted_antiwindup dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .measured_temp_i (meas_temp),
    .target_temp_i   (targ_temp),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .drive_o         (drive),
    .limited_o       (limited)
  );

  pid_duty_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .measured_temp_i (meas_temp),
    .target_temp_i   (targ_temp),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .drive_i         (drive),
    .limited_i       (limited),
    .awaiting_o      (awaiting),
    .mismatches_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("pid_setpoint_weighted_antiwindup test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  task automatic push_sample(input logic [TEMP_W-1:0] m, input logic [TEMP_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    meas_temp <= m;
    targ_temp <= t;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_setting();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= plan[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_plan();
    if ($urandom_range(0, 3) == 0) begin
      plan[REG_KP] = CFG_DAT_W'($urandom & 24'hFFFFFF);
      plan[REG_KI] = CFG_DAT_W'($urandom & 24'hFFFFFF);
      plan[REG_KD] = CFG_DAT_W'($urandom & 24'hFFFFFF);
      plan[REG_KB] = CFG_DAT_W'($urandom & 24'hFFFFFF);
    end else begin
      plan[REG_KP] = CFG_DAT_W'($urandom_range(0, 12 << FRAC_W));
      plan[REG_KI] = CFG_DAT_W'($urandom_range(0, 2048));
      plan[REG_KD] = CFG_DAT_W'($urandom_range(0, 20 << FRAC_W));
      plan[REG_KB] = CFG_DAT_W'($urandom_range(0, 8192));
    end
    plan[REG_B_WEIGHT] = CFG_DAT_W'(($urandom_range(0, 3) == 0) ? ($urandom & 16'hFFFF)
                                                                : $urandom_range(0, 32768));
    plan[REG_C_WEIGHT] = CFG_DAT_W'(($urandom_range(0, 3) == 0) ? ($urandom & 16'hFFFF)
                                                                : $urandom_range(0, 32768));
    if ($urandom_range(0, 7) == 0) begin
      plan[REG_MAX_TEMP] = CFG_DAT_W'($urandom_range(0, 300));
      plan[REG_MIN_TEMP] = CFG_DAT_W'($urandom_range(plan[REG_MAX_TEMP], 1023));
    end else begin
      plan[REG_MAX_TEMP] = CFG_DAT_W'($urandom_range(40, 1023));
      plan[REG_MIN_TEMP] = CFG_DAT_W'($urandom_range(0, 50));
    end
  endtask

  function automatic int pick_goal();
    int lo, hi;
    lo = int'(plan[REG_MIN_TEMP]) + 1;
    hi = int'(plan[REG_MAX_TEMP]);
    if (lo > hi) return $urandom_range(0, 1023);
    if ($urandom_range(0, 4) == 0) return $urandom_range(hi, 1023);
    return $urandom_range(lo, hi);
  endfunction

  // mostly a measured temperature creeping towards a held target, with noise and off requests
  task automatic run_phase(input int n_items);
    int goal, temp, r;
    goal = pick_goal();
    temp = $urandom_range(0, 1023);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) goal = pick_goal();
      if (r >= 90) begin
        push_sample(TEMP_W'($urandom & 10'h3FF), TEMP_W'($urandom & 10'h3FF));
      end else if (r >= 85) begin
        push_sample(TEMP_W'(temp), TEMP_W'($urandom_range(0, plan[REG_MIN_TEMP])));
      end else begin
        if (temp < goal) temp += $urandom_range(0, 5);
        else if (temp > goal) temp -= $urandom_range(0, 5);
        temp += int'($urandom_range(0, 2)) - 1;
        if (temp < 0) temp = 0;
        if (temp > 1023) temp = 1023;
        push_sample(TEMP_W'(temp), TEMP_W'(goal));
      end
    end
  endtask

  // output side: random stalls, long ready stretches, and now and then a long hold-off
  initial begin
    int run, gap, stalls, r;
    out_ready = 1'b0;
    stalls    = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      repeat (run) @(negedge clk_i);
      out_ready <= 1'b0;
      stalls++;
      r = $urandom_range(0, 99);
      if (stalls % 40 == 10) gap = 600;
      else if (r < 70) gap = $urandom_range(1, 3);
      else if (r < 95) gap = $urandom_range(4, 20);
      else gap = $urandom_range(40, 150);
      repeat (gap) @(negedge clk_i);
    end
  end

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    meas_temp = '0;
    targ_temp = '0;
    no_gaps   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // register defaults straight out of reset
    push_sample(10'd0, 10'd0);
    push_sample(10'd0, 10'd300);
    push_sample(10'd100, 10'd50);
    settle();

    plan[REG_KP]       = 24'd8192;
    plan[REG_KI]       = 24'd410;
    plan[REG_KD]       = 24'd4096;
    plan[REG_KB]       = 24'd2048;
    plan[REG_B_WEIGHT] = 24'd16384;
    plan[REG_C_WEIGHT] = 24'd16384;
    plan[REG_MAX_TEMP] = 24'd275;
    plan[REG_MIN_TEMP] = 24'd5;
    load_setting();
    push_sample(10'd150, 10'd150);   // zero proportional error; the derivative term still sees the earlier item's error
    push_sample(10'd0, 10'd0);
    push_sample(10'd0, 10'd5);       // target on the off threshold
    push_sample(10'd0, 10'd6);
    push_sample(10'd0, 10'd1023);    // target clamped, output saturates high
    push_sample(10'd0, 10'd1023);
    push_sample(10'd1023, 10'd0);    // off, back-calculation term carried over
    push_sample(10'd200, 10'd210);
    push_sample(10'd205, 10'd210);
    push_sample(10'd208, 10'd210);
    push_sample(10'd210, 10'd210);
    push_sample(10'd211, 10'd210);
    push_sample(10'd212, 10'd210);
    push_sample(10'd1023, 10'd1023);
    push_sample(10'd1023, 10'd275);
    push_sample(10'd275, 10'd276);
    push_sample(10'd0, 10'd275);
    push_sample(10'd1023, 10'd6);
    push_sample(10'd512, 10'd512);
    push_sample(10'd100, 10'd100);
    settle();

    plan[REG_KP]       = 24'hFFFFFF;
    plan[REG_KI]       = 24'hFFFFFF;
    plan[REG_KD]       = 24'hFFFFFF;
    plan[REG_KB]       = 24'hFFFFFF;
    plan[REG_B_WEIGHT] = 24'h00FFFF;
    plan[REG_C_WEIGHT] = 24'h00FFFF;
    plan[REG_MAX_TEMP] = 24'd1023;
    plan[REG_MIN_TEMP] = 24'd0;
    load_setting();
    run_phase(40);
    settle();

    plan[REG_KP]       = '0;
    plan[REG_KI]       = '0;
    plan[REG_KD]       = '0;
    plan[REG_KB]       = '0;
    plan[REG_B_WEIGHT] = '0;
    plan[REG_C_WEIGHT] = 24'd32768;
    plan[REG_MAX_TEMP] = 24'd1023;
    plan[REG_MIN_TEMP] = 24'd1023;   // min at max: heater always off
    load_setting();
    run_phase(40);
    settle();

    plan[REG_KP]       = 24'd20480;
    plan[REG_KI]       = 24'd1024;
    plan[REG_KD]       = 24'd0;
    plan[REG_KB]       = 24'd4096;
    plan[REG_B_WEIGHT] = 24'd32768;
    plan[REG_C_WEIGHT] = '0;
    plan[REG_MAX_TEMP] = '0;
    plan[REG_MIN_TEMP] = '0;
    load_setting();
    run_phase(40);
    settle();

    for (int p = 0; p < 7; p++) begin
      random_plan();
      no_gaps = (p % 3 == 1);
      load_setting();
      run_phase(110);
      settle();
    end

    while (awaiting != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("pid_setpoint_weighted_antiwindup test passed");
    end else begin
      $display("pid_setpoint_weighted_antiwindup test failed");
    end
    $finish;
  end

endmodule
